// ===== hdl/lpht_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the linear probing hash table.
package lpht_pkg;

  localparam int unsigned LogDepth = 10;
  localparam int unsigned Depth    = 1 << LogDepth;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ProbeW  = 5;

  localparam logic [ProbeW-1:0] MaxProbeReset = 5'd8;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [StatusW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [StatusW-1:0] ST_REMOVED   = 3'd1;
  localparam logic [StatusW-1:0] ST_FOUND     = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } slot_t;

  typedef struct packed {
    logic load;
    logic probe;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic finish;
  } dp_stat_t;

endpackage

// ===== hdl/lpht_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: clearing pass, idle and probe sequencing.
module lpht_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  lpht_pkg::dp_stat_t   stat_i,
  output lpht_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat_i.finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy        = busy_q;
  assign cmd_o.load  = (state_q == S_IDLE) && start;
  assign cmd_o.probe = (state_q == S_PROBE);
  assign cmd_o.clear = (state_q == S_CLEAR);

endmodule

// ===== hdl/lpht_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: request registers, slot memory, probe address and match logic.
module lpht_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lpht_pkg::ctrl_cmd_t               cmd_i,
  output lpht_pkg::dp_stat_t                stat_o,
  input  logic [lpht_pkg::CmdW-1:0]         cmd_req_i,
  input  logic [lpht_pkg::KeyW-1:0]         key_i,
  input  logic [lpht_pkg::ValW-1:0]         value_i,
  input  logic                              max_probe_we_i,
  input  logic [lpht_pkg::ProbeW-1:0]       max_probe_i,
  output logic                              done_o,
  output logic [lpht_pkg::StatusW-1:0]      status_o,
  output logic [lpht_pkg::ValW-1:0]         value_out_o
);

  localparam int unsigned AddrW = lpht_pkg::LogDepth;

  lpht_pkg::slot_t mem [lpht_pkg::Depth];

  logic [lpht_pkg::ProbeW-1:0]  max_probe_q;
  logic [lpht_pkg::CmdW-1:0]    cmd_q;
  logic [lpht_pkg::KeyW-1:0]    key_q;
  logic [lpht_pkg::ValW-1:0]    val_q;
  logic [AddrW-1:0]             addr_q;
  logic [AddrW-1:0]             rd_addr_q;
  logic [AddrW-1:0]             clr_cnt_q;
  logic [lpht_pkg::ProbeW-1:0]  issued_q;
  logic                         rd_vld_q;
  lpht_pkg::slot_t              rd_q;
  logic                         done_q;
  logic [lpht_pkg::StatusW-1:0] status_q;
  logic [lpht_pkg::ValW-1:0]    value_q;

  logic                         is_ins, is_rm, is_lk;
  logic [lpht_pkg::ProbeW-1:0]  limit;
  logic                         issue, hit, finish;
  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr;
  lpht_pkg::slot_t              mem_wdata;
  logic [lpht_pkg::StatusW-1:0] status_d;
  logic [lpht_pkg::ValW-1:0]    value_d;

  assign is_ins = (cmd_q == lpht_pkg::CMD_INSERT);
  assign is_rm  = (cmd_q == lpht_pkg::CMD_REMOVE);
  assign is_lk  = (cmd_q == lpht_pkg::CMD_LOOKUP);

  // The unused command code probes nothing and so ends as a miss.
  assign limit = (is_ins || is_rm || is_lk) ? max_probe_q : '0;
  assign issue = cmd_i.probe && (issued_q < limit);

  assign hit = rd_vld_q &&
               (is_ins ? !rd_q.valid
                       : (rd_q.valid && (rd_q.key == key_q) && (is_rm || is_lk)));

  // A miss is final once every probe has been issued and the last read evaluated.
  assign finish = cmd_i.probe && (hit || (issued_q >= limit));

  assign stat_o.finish     = finish;
  assign stat_o.clear_last = cmd_i.clear && (clr_cnt_q == {AddrW{1'b1}});

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr_q;
    mem_wdata = rd_q;
    if (cmd_i.clear) begin
      mem_we          = 1'b1;
      mem_waddr       = clr_cnt_q;
      mem_wdata.valid = 1'b0;
    end else if (cmd_i.probe && hit && is_ins) begin
      mem_we          = 1'b1;
      mem_wdata.valid = 1'b1;
      mem_wdata.key   = key_q;
      mem_wdata.value = val_q;
    end else if (cmd_i.probe && hit && is_rm) begin
      mem_we          = 1'b1;
      mem_wdata.valid = 1'b0;
    end
  end

  always_comb begin
    value_d = '0;
    if (hit) begin
      if (is_ins) begin
        status_d = lpht_pkg::ST_INSERTED;
      end else if (is_rm) begin
        status_d = lpht_pkg::ST_REMOVED;
        value_d  = rd_q.value;
      end else begin
        status_d = lpht_pkg::ST_FOUND;
        value_d  = rd_q.value;
      end
    end else begin
      status_d = is_ins ? lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_q      <= mem[addr_q];
      rd_addr_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= cmd_req_i;
      key_q  <= key_i;
      val_q  <= value_i;
    end
    if (finish) begin
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_probe_q <= lpht_pkg::MaxProbeReset;
      addr_q      <= '0;
      issued_q    <= '0;
      rd_vld_q    <= 1'b0;
      clr_cnt_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      if (max_probe_we_i) begin
        max_probe_q <= max_probe_i;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        addr_q   <= key_i[AddrW-1:0];
        issued_q <= '0;
      end else if (issue) begin
        addr_q   <= addr_q + 1'b1;
        issued_q <= issued_q + 1'b1;
      end
      rd_vld_q <= issue && !finish;
      done_q   <= finish;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign value_out_o = value_q;

`ifndef SYNTHESIS
  a_no_done_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> !done_q)
    else $error("result strobe raised during the clearing pass");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe |-> (issued_q <= max_probe_q))
    else $error("more probes issued than the probe limit");
`endif

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// Top level of the linear probing hash table: controller plus datapath.
//
// After reset the block clears the valid bits of all 1024 slots in turn and
// holds busy high meanwhile; write max_probe only while no request is
// in flight, since a search reads the probe limit on every cycle.
// A request is taken when start is high and busy is low. It then probes one
// slot per cycle through the single read port of the slot memory. The result
// is shown on done_o for exactly one cycle, and busy drops in that same cycle
// so the next request can be taken on the following edge. A hit ends the
// search at the slot that hit. The receiver cannot stall: each result must
// be captured when done_o is high.
module linear_probe_hash_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [lpht_pkg::CmdW-1:0]         cmd_i,
  input  logic [lpht_pkg::KeyW-1:0]         key_i,
  input  logic [lpht_pkg::ValW-1:0]         value_i,
  input  logic                              max_probe_we_i,
  input  logic [lpht_pkg::ProbeW-1:0]       max_probe_i,
  output logic                              done_o,
  output logic [lpht_pkg::StatusW-1:0]      status_o,
  output logic [lpht_pkg::ValW-1:0]         value_out_o
);

  lpht_pkg::ctrl_cmd_t ctrl_cmd;
  lpht_pkg::dp_stat_t  dp_stat;

  lpht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (ctrl_cmd)
  );

  lpht_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .cmd_req_i      (cmd_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .max_probe_we_i (max_probe_we_i),
    .max_probe_i    (max_probe_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .value_out_o    (value_out_o)
  );

`ifndef SYNTHESIS
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while the block is still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after a request transfer");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the linear probing hash table with directed and random traffic.
module tb_top;

  localparam logic [lpht_pkg::CmdW-1:0] CMD_RESERVED = 2'd3;
  localparam int unsigned PoolSize = 48;

  typedef struct packed {
    logic [lpht_pkg::StatusW-1:0] status;
    logic [lpht_pkg::ValW-1:0]    value;
  } outcome_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [lpht_pkg::CmdW-1:0]    cmd_i;
  logic [lpht_pkg::KeyW-1:0]    key_i;
  logic [lpht_pkg::ValW-1:0]    value_i;
  logic                         max_probe_we_i;
  logic [lpht_pkg::ProbeW-1:0]  max_probe_i;
  logic                         done_o;
  logic [lpht_pkg::StatusW-1:0] status_o;
  logic [lpht_pkg::ValW-1:0]    value_out_o;

  // Shadow copy of the slot store and of the probe limit register.
  logic                        slot_used [lpht_pkg::Depth];
  logic [lpht_pkg::KeyW-1:0]   slot_key_q [lpht_pkg::Depth];
  logic [lpht_pkg::ValW-1:0]   slot_val_q [lpht_pkg::Depth];
  logic [lpht_pkg::ProbeW-1:0] probe_limit;

  outcome_t                  pending_outcomes [$];
  logic [lpht_pkg::KeyW-1:0] recent_keys [$];
  outcome_t                  oldest;
  int unsigned               mismatch_count;
  bit                        idle_enabled;

  linear_probe_hash_table uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .max_probe_we_i (max_probe_we_i),
    .max_probe_i    (max_probe_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .value_out_o    (value_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    if (mismatch_count < 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    end
    mismatch_count++;
  endfunction

  // Walks the probe sequence from the home slot exactly as the hardware should.
  function automatic void probe_slots(input logic [lpht_pkg::CmdW-1:0] op,
                                      input logic [lpht_pkg::KeyW-1:0] k,
                                      input logic [lpht_pkg::ValW-1:0] v,
                                      output outcome_t res);
    int unsigned i;
    int unsigned s;
    res.status = lpht_pkg::ST_NOT_FOUND;
    res.value  = '0;
    if (op == lpht_pkg::CMD_INSERT) begin
      res.status = lpht_pkg::ST_FULL;
      for (i = 0; i < probe_limit; i++) begin
        s = (k + i) & (lpht_pkg::Depth - 1);
        if (!slot_used[s]) begin
          slot_used[s]  = 1'b1;
          slot_key_q[s] = k;
          slot_val_q[s] = v;
          res.status    = lpht_pkg::ST_INSERTED;
          break;
        end
      end
    end else if (op == lpht_pkg::CMD_REMOVE || op == lpht_pkg::CMD_LOOKUP) begin
      for (i = 0; i < probe_limit; i++) begin
        s = (k + i) & (lpht_pkg::Depth - 1);
        if (slot_used[s] && slot_key_q[s] == k) begin
          res.value = slot_val_q[s];
          if (op == lpht_pkg::CMD_REMOVE) begin
            slot_used[s] = 1'b0;
            res.status   = lpht_pkg::ST_REMOVED;
          end else begin
            res.status = lpht_pkg::ST_FOUND;
          end
          break;
        end
      end
    end
  endfunction

  // Every request produces one result, checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch("unexpected result status", '0, 64'(status_o));
      end else begin
        oldest = pending_outcomes.pop_front();
        if (status_o !== oldest.status) begin
          note_mismatch("status", 64'(oldest.status), 64'(status_o));
        end
        if (value_out_o !== oldest.value) begin
          note_mismatch("value_out", 64'(oldest.value), 64'(value_out_o));
        end
      end
    end
  end

  // Start stays high after a transfer; the next call either carries a new request
  // at the following falling edge or drops start there.
  task automatic send_request(input logic [lpht_pkg::CmdW-1:0] op,
                              input logic [lpht_pkg::KeyW-1:0] k,
                              input logic [lpht_pkg::ValW-1:0] v);
    outcome_t res;
    @(negedge clk_i);
    if (idle_enabled && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
    start   <= 1'b1;
    cmd_i   <= op;
    key_i   <= k;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    probe_slots(op, k, v, res);
    pending_outcomes.push_back(res);
    if (op == lpht_pkg::CMD_INSERT) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > PoolSize) void'(recent_keys.pop_front());
    end
  endtask

  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_outcomes.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_probe_limit(input logic [lpht_pkg::ProbeW-1:0] lim);
    drain_results();
    @(negedge clk_i);
    max_probe_we_i <= 1'b1;
    max_probe_i    <= lim;
    @(posedge clk_i);
    probe_limit = lim;
    @(negedge clk_i);
    max_probe_we_i <= 1'b0;
  endtask

  function automatic logic [lpht_pkg::KeyW-1:0] clustered_key(input int unsigned base,
                                                               input int unsigned span);
    logic [lpht_pkg::KeyW-1:0] k;
    int unsigned               idx;
    k = $urandom();
    idx = (base + $urandom_range(0, span - 1)) % lpht_pkg::Depth;
    k[lpht_pkg::LogDepth-1:0] = idx[lpht_pkg::LogDepth-1:0];
    return k;
  endfunction

  // Reset value of the probe limit, wrap from the last slot to slot zero, all commands.
  task automatic test_basic_ops();
    send_request(lpht_pkg::CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lpht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lpht_pkg::CMD_INSERT, 32'h0000_03FF, 32'h1234_5678);
    send_request(lpht_pkg::CMD_LOOKUP, 32'h0000_03FF, 32'hFFFF_FFFF);
    send_request(lpht_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lpht_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(lpht_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lpht_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Duplicate keys act on the first match, and a freed slot does not end the search.
  task automatic test_duplicates_and_holes();
    send_request(lpht_pkg::CMD_INSERT, 32'hA5A5_0100, 32'h0000_0001);
    send_request(lpht_pkg::CMD_INSERT, 32'hA5A5_0100, 32'h0000_0002);
    send_request(lpht_pkg::CMD_INSERT, 32'h5A5A_0100, 32'h0000_0003);
    send_request(lpht_pkg::CMD_REMOVE, 32'hA5A5_0100, 32'h0000_0000);
    send_request(lpht_pkg::CMD_LOOKUP, 32'hA5A5_0100, 32'h0000_0000);
    send_request(lpht_pkg::CMD_LOOKUP, 32'h5A5A_0100, 32'h0000_0000);
  endtask

  // Probe limits of one, zero and the largest value, 31.
  task automatic test_probe_limits();
    write_probe_limit(5'd1);
    send_request(lpht_pkg::CMD_INSERT, 32'h5A5A_0100, 32'h0000_0004);
    send_request(lpht_pkg::CMD_INSERT, 32'hA5A5_0100, 32'h0000_0005);
    send_request(lpht_pkg::CMD_LOOKUP, 32'hA5A5_0100, 32'h0000_0000);
    write_probe_limit(5'd0);
    send_request(lpht_pkg::CMD_INSERT, 32'h1111_2222, 32'h0000_0006);
    send_request(lpht_pkg::CMD_LOOKUP, 32'h5A5A_0100, 32'h0000_0000);
    send_request(lpht_pkg::CMD_REMOVE, 32'h5A5A_0100, 32'h0000_0000);
    write_probe_limit(5'd31);
    send_request(lpht_pkg::CMD_LOOKUP, 32'hA5A5_0100, 32'h0000_0000);
    send_request(lpht_pkg::CMD_INSERT, 32'hA5A5_0100, 32'h0000_0007);
  endtask

  // Mostly keys crowded into a narrow band of home slots so that clusters, hits,
  // duplicates and full tables all occur; the rest are arbitrary keys.
  task automatic test_random_traffic(input int unsigned items,
                                     input logic [lpht_pkg::ProbeW-1:0] lim,
                                     input int unsigned base, input int unsigned span,
                                     input bit gaps);
    int unsigned               n;
    int unsigned               r;
    logic [lpht_pkg::CmdW-1:0] op;
    logic [lpht_pkg::KeyW-1:0] k;
    write_probe_limit(lim);
    idle_enabled = gaps;
    for (n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = lpht_pkg::CMD_INSERT;
      else if (r < 65) op = lpht_pkg::CMD_REMOVE;
      else if (r < 95) op = lpht_pkg::CMD_LOOKUP;
      else op = CMD_RESERVED;
      r = $urandom_range(0, 99);
      if (op != lpht_pkg::CMD_INSERT && r < 70 && recent_keys.size() != 0) begin
        k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end else if (r < 92) begin
        k = clustered_key(base, span);
      end else begin
        k = $urandom();
      end
      send_request(op, k, $urandom());
      if ($urandom_range(0, 99) == 0) drain_results();
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = lpht_pkg::CMD_INSERT;
    key_i          = '0;
    value_i        = '0;
    max_probe_we_i = 1'b0;
    max_probe_i    = '0;
    probe_limit    = lpht_pkg::MaxProbeReset;
    mismatch_count = 0;
    idle_enabled   = 1'b1;
    for (int s = 0; s < lpht_pkg::Depth; s++) begin
      slot_used[s] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops();
    test_duplicates_and_holes();
    test_probe_limits();
    test_random_traffic(200, 5'd8, $urandom_range(0, lpht_pkg::Depth - 1), 64, 1'b1);
    test_random_traffic(120, 5'd1, $urandom_range(0, lpht_pkg::Depth - 1), 16, 1'b1);
    test_random_traffic(180, 5'd16, lpht_pkg::Depth - 12, 24, 1'b0);
    test_random_traffic(150, 5'd31, $urandom_range(0, lpht_pkg::Depth - 1), 40, 1'b1);
    test_random_traffic(30, 5'd0, $urandom_range(0, lpht_pkg::Depth - 1), 32, 1'b1);
    test_random_traffic(220, 5'($urandom_range(2, 15)),
                        $urandom_range(0, lpht_pkg::Depth - 1), 32, 1'b1);

    drain_results();
    repeat (40) @(posedge clk_i);
    while (pending_outcomes.size() != 0) begin
      oldest = pending_outcomes.pop_front();
      note_mismatch("missing result status", 64'(oldest.status), '0);
    end

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== linear_probe_hash_table.f =====
hdl/lpht_pkg.sv
hdl/lpht_ctrl.sv
hdl/lpht_datapath.sv
hdl/linear_probe_hash_table.sv
test/tb_top.sv
